>>> sv/lcr_pkg.sv
// shared types, constants and helpers for the longest consecutive run block
package lcr_pkg;

   localparam int MAX_ITEMS = 64;
   localparam int ADDR_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
   localparam int KEY_W     = 32;
   localparam int LEN_W     = 7;
   localparam int EXT_W     = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam logic [LEN_W-1:0] LEN_MAX  = {LEN_W{1'b1}};
   localparam logic [KEY_W-1:0] KEY_BIAS = {1'b1, {(KEY_W-1){1'b0}}};

   typedef struct packed {
      logic signed [KEY_W-1:0] value;
      logic                    last;
   } req_type;

   typedef struct packed {
      logic [LEN_W-1:0] longest_length;
      logic             overflowed;
   } rsp_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic clear;
      logic outer_start;
      logic outer_rd;
      logic take_key;
      logic scan_pred;
      logic scan_succ;
      logic scan_run;
      logic chase;
      logic commit;
      logic advance;
   } lcr_ctl_type;

   // status from datapath to controller
   typedef struct packed {
      logic key_min;
      logic key_max;
      logic hit;
      logic miss_done;
      logic outer_last;
   } lcr_sts_type;

   function automatic logic [LEN_W-1:0] sat_len(input logic [CNT_W-1:0] v);
      logic [EXT_W-1:0] x;
      x = EXT_W'(v);
      if (x > EXT_W'(LEN_MAX)) begin
         return LEN_MAX;
      end
      return x[LEN_W-1:0];
   endfunction

endpackage

>>> sv/lcr_ram.sv
// generic single-write, single-read ram with registered read data
module lcr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/lcr_datapath.sv
// datapath: value store, counters, scan compare and best-length tracking
module lcr_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  lcr_pkg::req_type     req_payload,
   input  lcr_pkg::lcr_ctl_type ctl,
   output lcr_pkg::lcr_sts_type sts,
   output lcr_pkg::rsp_type     rsp_payload
);
   import lcr_pkg::*;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic [ADDR_W-1:0] outer_ff, outer_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              rd_vld_ff, rd_vld_in;
   logic              rd_last_ff, rd_last_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [KEY_W-1:0]  target_ff, target_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic [CNT_W-1:0]  best_ff, best_in;

   logic              full;
   logic              wr_en;
   logic              issue;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [KEY_W-1:0]  rd_data;
   logic              hit;

   assign full  = (count_ff == CNT_W'(MAX_ITEMS));
   assign wr_en = ctl.load && !full;
   assign issue = ctl.scan_run && (scan_ff != count_ff);
   assign rd_en   = ctl.outer_rd || issue;
   assign rd_addr = ctl.outer_rd ? outer_ff : scan_ff[ADDR_W-1:0];

   lcr_ram #(
      .WIDTH (KEY_W),
      .DEPTH (MAX_ITEMS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_payload.value ^ KEY_BIAS),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign hit = rd_vld_ff && (rd_data == target_ff);

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (ctl.clear) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end else if (ctl.load) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      outer_in   = outer_ff;
      scan_in    = scan_ff;
      key_in     = key_ff;
      target_in  = target_ff;
      len_in     = len_ff;
      best_in    = best_ff;
      rd_vld_in  = issue;
      rd_last_in = issue && ((scan_ff + CNT_W'(1)) == count_ff);
      if (ctl.outer_start) begin
         outer_in = '0;
         best_in  = '0;
      end
      if (ctl.advance) begin
         outer_in = outer_ff + ADDR_W'(1);
      end
      if (ctl.take_key) begin
         key_in = rd_data;
         len_in = CNT_W'(1);
      end
      if (ctl.scan_pred) begin
         target_in = key_ff - KEY_W'(1);
         scan_in   = '0;
      end
      if (ctl.scan_succ) begin
         target_in = key_ff + KEY_W'(1);
         scan_in   = '0;
      end
      if (issue) begin
         scan_in = scan_ff + CNT_W'(1);
      end
      if (ctl.chase) begin
         key_in = target_ff;
         len_in = len_ff + CNT_W'(1);
      end
      if (ctl.commit && (len_ff > best_ff)) begin
         best_in = len_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         rd_vld_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      outer_ff   <= outer_in;
      scan_ff    <= scan_in;
      rd_last_ff <= rd_last_in;
      key_ff     <= key_in;
      target_ff  <= target_in;
      len_ff     <= len_in;
      best_ff    <= best_in;
   end

   assign sts.key_min    = (key_ff == '0);
   assign sts.key_max    = (key_ff == '1);
   assign sts.hit        = hit;
   assign sts.miss_done  = rd_vld_ff && rd_last_ff && !hit;
   assign sts.outer_last = ((CNT_W'(outer_ff) + CNT_W'(1)) == count_ff);

   assign rsp_payload.longest_length = sat_len(best_ff);
   assign rsp_payload.overflowed     = ovf_ff;

endmodule

>>> sv/lcr_ctrl.sv
// controller: load phase, run search sequencing and result handshake
module lcr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  lcr_pkg::lcr_sts_type sts,
   output lcr_pkg::lcr_ctl_type ctl
);
   import lcr_pkg::*;

   localparam logic [3:0] S_LOAD       = 4'd0;
   localparam logic [3:0] S_INIT       = 4'd1;
   localparam logic [3:0] S_OUT_RD     = 4'd2;
   localparam logic [3:0] S_KEY        = 4'd3;
   localparam logic [3:0] S_PRED_START = 4'd4;
   localparam logic [3:0] S_PRED_SCAN  = 4'd5;
   localparam logic [3:0] S_SUCC_START = 4'd6;
   localparam logic [3:0] S_SUCC_SCAN  = 4'd7;
   localparam logic [3:0] S_COMMIT     = 4'd8;
   localparam logic [3:0] S_NEXT       = 4'd9;
   localparam logic [3:0] S_RESP       = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       accept;

   assign req_stall = (state_ff != S_LOAD);
   assign rsp_valid = (state_ff == S_RESP);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         S_LOAD: begin
            ctl.load = accept;
            if (accept && req_last) begin
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            ctl.outer_start = 1'b1;
            state_in        = S_OUT_RD;
         end
         S_OUT_RD: begin
            ctl.outer_rd = 1'b1;
            state_in     = S_KEY;
         end
         S_KEY: begin
            ctl.take_key = 1'b1;
            state_in     = S_PRED_START;
         end
         S_PRED_START: begin
            // the smallest key has no predecessor
            if (sts.key_min) begin
               state_in = S_SUCC_START;
            end else begin
               ctl.scan_pred = 1'b1;
               state_in      = S_PRED_SCAN;
            end
         end
         S_PRED_SCAN: begin
            ctl.scan_run = 1'b1;
            priority if (sts.hit) begin
               state_in = S_NEXT;
            end else if (sts.miss_done) begin
               state_in = S_SUCC_START;
            end
         end
         S_SUCC_START: begin
            // no wrap past the largest key
            if (sts.key_max) begin
               state_in = S_COMMIT;
            end else begin
               ctl.scan_succ = 1'b1;
               state_in      = S_SUCC_SCAN;
            end
         end
         S_SUCC_SCAN: begin
            ctl.scan_run = 1'b1;
            priority if (sts.hit) begin
               ctl.chase = 1'b1;
               state_in  = S_SUCC_START;
            end else if (sts.miss_done) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            ctl.commit = 1'b1;
            state_in   = S_NEXT;
         end
         S_NEXT: begin
            if (sts.outer_last) begin
               state_in = S_RESP;
            end else begin
               ctl.advance = 1'b1;
               state_in    = S_OUT_RD;
            end
         end
         S_RESP: begin
            if (!rsp_stall) begin
               ctl.clear = 1'b1;
               state_in  = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sv/longest_consecutive_run_top.sv
// top level of the longest consecutive run block
// The block collects a set of signed 32-bit values on the req channel, one
// transfer per cycle while req_stall is low, and stores up to MAX_ITEMS of
// them; further values of the set are dropped and reported through
// overflowed. The transfer with last set ends the set (it is stored too if
// there is room). Then req_stall goes high and the block searches its n
// stored values for the longest run of consecutive integers. For every
// stored value it fetches the value, runs a predecessor scan through the
// single read port of the store and then steps on. A value without a
// predecessor also gets successor scans that chase its run one value at a
// time, then a compare against the best length. Every copy of a run's lowest
// value chases the run again, so heavy duplication lengthens the search. The
// one result then sits on the rsp channel with rsp_valid high and holds
// steady while rsp_stall is high; once it is transferred the block clears
// its count and takes a new set the next cycle. Loading thus runs at one
// value per cycle, but the block takes no new set until the search and the
// result transfer are done. Reset returns the block to the loading phase
// with an empty store and the overflow flag cleared.
module longest_consecutive_run_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lcr_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lcr_pkg::rsp_type rsp_payload
);
   import lcr_pkg::*;

   lcr_ctl_type ctl;
   lcr_sts_type sts;

   lcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_payload.last),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   lcr_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .ctl         (ctl),
      .sts         (sts),
      .rsp_payload (rsp_payload)
   );

endmodule
